FILE: sv/date_difference_in_days_defines.svh
// ----------------------------------------------------------------------------
// date_difference_in_days_defines.svh
// Assertion macros shared by the checker of the date difference block.
// ----------------------------------------------------------------------------
`ifndef DATE_DIFFERENCE_IN_DAYS_DEFINES_SVH
`define DATE_DIFFERENCE_IN_DAYS_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define DDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ddd assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define DDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ddd assertion failed");

// Next-cycle implication that is also checked across reset.
`define DDD_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ddd assertion failed");

`endif

FILE: sv/ddd_pkg.sv
// ----------------------------------------------------------------------------
// ddd_pkg
// Widths, constants, types and the month table of the date difference block.
// ----------------------------------------------------------------------------
package ddd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DAYS_W  = 23;   // result width, signed
    localparam int DN_W    = 23;   // day number width, unsigned
    localparam int Q100_W  = 8;    // year / 100 for a 14-bit year
    localparam int MD_W    = 9;    // month start + leap + day, up to 397

    // floor(y / 100) = (y * DIV100_K) >> DIV100_SH, exact for y < 2^15
    localparam int DIV100_SH = 21;
    localparam logic [14:0] DIV100_K = 15'd20972;
    localparam int PROD_W = YEAR_W + 15;

    localparam logic signed [DAYS_W-1:0] DAYS_MAX = 23'sh3FFFFF;
    localparam logic signed [DAYS_W-1:0] DAYS_MIN = 23'sh400000;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    // stage load enables, A..C in the day number pipe, D at the output
    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
        logic en_d;
    } t_pipe_ctl;

    // days of whole months before month m in a common year;
    // month zero has none, months past December count the full year
    function automatic logic [MD_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [MD_W-1:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd365;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/ddd_if.sv
// ----------------------------------------------------------------------------
// ddd_if
// Valid/ready channels of the date difference block: date pairs in,
// day counts out.
// ----------------------------------------------------------------------------
interface ddd_in_if;
    import ddd_pkg::*;

    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year_first;
    logic [MONTH_W-1:0] month_first;
    logic [DAY_W-1:0]   day_first;
    logic [YEAR_W-1:0]  year_second;
    logic [MONTH_W-1:0] month_second;
    logic [DAY_W-1:0]   day_second;
    logic               include_end_day;

    modport source (
        output valid, year_first, month_first, day_first,
               year_second, month_second, day_second, include_end_day,
        input  ready
    );
    modport sink (
        input  valid, year_first, month_first, day_first,
               year_second, month_second, day_second, include_end_day,
        output ready
    );
endinterface

interface ddd_out_if;
    import ddd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DAYS_W-1:0] days_between;

    modport source (output valid, days_between, input ready);
    modport sink   (input valid, days_between, output ready);
endinterface

FILE: sv/date_difference_in_days.sv
// ----------------------------------------------------------------------------
// date_difference_in_days
// Signed Gregorian day count between two dates, fully pipelined.
// ----------------------------------------------------------------------------
// Each transaction on i_in carries two dates (year, month, day) and the
// include_end_day flag; the matching transaction on o_out carries the signed
// number of days from the first date to the second. With include_end_day set
// the magnitude grows by one, so equal dates give +1. Leap years follow the
// Gregorian rule and run proleptically back to year zero. Fields are not
// range checked: month zero counts no whole months, months past December
// count the whole year, and the day of month is added as given. Results
// outside -4194304..4194303 saturate. The block takes one date pair every
// clock cycle while o_out is not stalled: three stages build the two day
// numbers side by side (reciprocal multiply for year/100, century and leap
// terms, final sum) and a fourth stage subtracts, adjusts and saturates into
// the output register. Back-pressure on o_out only stops the pipe once
// every stage holds a transaction; empty stages keep filling meanwhile.
// No reset-time sweep.
// ----------------------------------------------------------------------------
module date_difference_in_days (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ddd_in_if.sink     i_in,
    ddd_out_if.source  o_out
);
    import ddd_pkg::*;

    // valid bits per stage, D being the output register
    logic r_va, r_vb, r_vc, r_vd;
    logic r_end_a, r_end_b, r_end_c;
    logic w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d;
    t_pipe_ctl w_ctl;
    t_date     w_date_first;
    t_date     w_date_second;
    logic [DN_W-1:0] w_dn_first;
    logic [DN_W-1:0] w_dn_second;
    logic signed [DAYS_W-1:0] w_days;

    // a stage may load when it is empty or its contents move on
    assign w_rdy_d = !r_vd || o_out.ready;
    assign w_rdy_c = !r_vc || w_rdy_d;
    assign w_rdy_b = !r_vb || w_rdy_c;
    assign w_rdy_a = !r_va || w_rdy_b;

    assign w_ctl.en_a = w_rdy_a && i_in.valid;
    assign w_ctl.en_b = w_rdy_b && r_va;
    assign w_ctl.en_c = w_rdy_c && r_vb;
    assign w_ctl.en_d = w_rdy_d && r_vc;

    assign i_in.ready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (w_rdy_a) r_va <= i_in.valid;
            if (w_rdy_b) r_vb <= r_va;
            if (w_rdy_c) r_vc <= r_vb;
            if (w_rdy_d) r_vd <= r_vc;
        end
    end

    // end-day flag rides along with the day number stages
    always_ff @(posedge i_clk) begin
        if (w_ctl.en_a) r_end_a <= i_in.include_end_day;
        if (w_ctl.en_b) r_end_b <= r_end_a;
        if (w_ctl.en_c) r_end_c <= r_end_b;
    end

    assign w_date_first.year   = i_in.year_first;
    assign w_date_first.month  = i_in.month_first;
    assign w_date_first.day    = i_in.day_first;
    assign w_date_second.year  = i_in.year_second;
    assign w_date_second.month = i_in.month_second;
    assign w_date_second.day   = i_in.day_second;

    ddd_day_num u_dn_first (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_date    (w_date_first),
        .o_day_num (w_dn_first)
    );

    ddd_day_num u_dn_second (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_date    (w_date_second),
        .o_day_num (w_dn_second)
    );

    ddd_diff_out u_diff (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_dn_first  (w_dn_first),
        .i_dn_second (w_dn_second),
        .i_end_day   (r_end_c),
        .o_days      (w_days)
    );

    assign o_out.valid        = r_vd;
    assign o_out.days_between = w_days;

endmodule

FILE: sv/ddd_day_num.sv
// ----------------------------------------------------------------------------
// ddd_day_num
// Three-stage day number of one date, counted from the start of year zero.
// ----------------------------------------------------------------------------
module ddd_day_num (
    input  logic                  i_clk,
    input  ddd_pkg::t_pipe_ctl    i_ctl,
    input  ddd_pkg::t_date        i_date,
    output logic [ddd_pkg::DN_W-1:0] o_day_num
);
    import ddd_pkg::*;

    // stage A: year / 100 by reciprocal multiply
    logic [PROD_W-1:0]  n_prod;
    logic [YEAR_W-1:0]  r_a_year;
    logic [MONTH_W-1:0] r_a_month;
    logic [DAY_W-1:0]   r_a_day;
    logic [Q100_W-1:0]  r_a_q100;

    assign n_prod = PROD_W'(i_date.year) * PROD_W'(DIV100_K);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_a_year  <= i_date.year;
            r_a_month <= i_date.month;
            r_a_day   <= i_date.day;
            r_a_q100  <= n_prod[DIV100_SH +: Q100_W];
        end
    end

    // stage B: century terms, leap flag, whole-year and in-year parts
    logic [YEAR_W-1:0] w_q100x;
    logic              w_rem0;
    logic [Q100_W-1:0] w_c100;
    logic [Q100_W:0]   w_c100p3;
    logic              w_leap;
    logic [YEAR_W:0]   w_y4p;
    logic [DN_W-1:0]   n_b_yr;
    logic [MD_W-1:0]   n_b_md;
    logic [DN_W-1:0]   r_b_yr;
    logic [Q100_W-1:0] r_b_c100;
    logic [Q100_W-2:0] r_b_c400;
    logic [MD_W-1:0]   r_b_md;

    assign w_q100x  = YEAR_W'(r_a_q100) * YEAR_W'(100);
    assign w_rem0   = (w_q100x == r_a_year);
    assign w_c100   = r_a_q100 + Q100_W'(!w_rem0);        // ceil(y / 100)
    assign w_c100p3 = {1'b0, w_c100} + (Q100_W+1)'(3);     // ceil(y / 400) below
    assign w_leap   = (r_a_year[1:0] == 2'd0) && (!w_rem0 || (r_a_q100[1:0] == 2'd0));
    assign w_y4p    = {1'b0, r_a_year} + (YEAR_W+1)'(3);   // ceil(y / 4) below
    assign n_b_yr   = DN_W'(r_a_year) * DN_W'(365) + DN_W'(w_y4p[YEAR_W:2]);
    assign n_b_md   = month_start(r_a_month)
                    + MD_W'(w_leap && (r_a_month >= MONTH_W'(3)))
                    + MD_W'(r_a_day);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_b) begin
            r_b_yr   <= n_b_yr;
            r_b_c100 <= w_c100;
            r_b_c400 <= w_c100p3[Q100_W:2];
            r_b_md   <= n_b_md;
        end
    end

    // stage C: final sum
    logic [DN_W-1:0] r_c_dn;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_c) begin
            r_c_dn <= r_b_yr - DN_W'(r_b_c100) + DN_W'(r_b_c400) + DN_W'(r_b_md);
        end
    end

    assign o_day_num = r_c_dn;

endmodule

FILE: sv/ddd_diff_out.sv
// ----------------------------------------------------------------------------
// ddd_diff_out
// Output stage: signed difference, end-day adjustment, saturation.
// ----------------------------------------------------------------------------
module ddd_diff_out (
    input  logic                              i_clk,
    input  ddd_pkg::t_pipe_ctl                i_ctl,
    input  logic [ddd_pkg::DN_W-1:0]          i_dn_first,
    input  logic [ddd_pkg::DN_W-1:0]          i_dn_second,
    input  logic                              i_end_day,
    output logic signed [ddd_pkg::DAYS_W-1:0] o_days
);
    import ddd_pkg::*;

    logic signed [DN_W:0]     w_diff;
    logic signed [DN_W:0]     w_adj;
    logic signed [DAYS_W-1:0] n_days;
    logic signed [DAYS_W-1:0] r_days;

    assign w_diff = $signed({1'b0, i_dn_second}) - $signed({1'b0, i_dn_first});

    always_comb begin
        w_adj = w_diff;
        if (i_end_day) begin
            w_adj = w_diff[DN_W] ? w_diff - (DN_W+1)'(1) : w_diff + (DN_W+1)'(1);
        end
        // out of the 23-bit range when the two top bits differ
        if (w_adj[DN_W] != w_adj[DN_W-1]) begin
            n_days = w_adj[DN_W] ? DAYS_MIN : DAYS_MAX;
        end else begin
            n_days = w_adj[DAYS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_d) begin
            r_days <= n_days;
        end
    end

    assign o_days = r_days;

endmodule

FILE: sv/ddd_checker.sv
// ----------------------------------------------------------------------------
// ddd_checker
// Port-level checks of the date difference block, bound to its top level.
// ----------------------------------------------------------------------------
`include "date_difference_in_days_defines.svh"

module ddd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [ddd_pkg::DAYS_W-1:0] i_out_days
);
    import ddd_pkg::*;

    // reset empties the output register
    `DDD_ASSERT_NXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

    // with nothing waiting at the output every stage can move, so input is taken
    `DDD_ASSERT_IMP(a_ready_when_drained, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // a result held by back-pressure stays put
    `DDD_ASSERT_NXT(a_hold_stalled, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                    i_out_valid && $stable(i_out_days))

endmodule

bind date_difference_in_days ddd_checker u_ddd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_days  (o_out.days_between)
);
